### hw/rtl/plh_pkg.sv
// Package for the peak level history block: sizes, payload types and codes.
`timescale 1ns / 1ps
package plh_pkg;

  localparam int MAX_CHANNELS  = 8;
  localparam int HISTORY_DEPTH = 256;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 40;
  localparam int CH_W     = $clog2(MAX_CHANNELS);
  localparam int CHCNT_W  = 4;
  localparam int SLOT_W   = $clog2(HISTORY_DEPTH);
  localparam int HLEN_W   = 9;
  localparam int FRAG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 40;

  localparam logic [FRAG_W-1:0]  FRAG_RESET  = 16'd1024;
  localparam logic [HLEN_W-1:0]  HLEN_RESET  = 9'd16;
  localparam logic [CHCNT_W-1:0] CHCNT_RESET = 4'd2;
  localparam logic [TIME_W-1:0]  LIMIT_RESET = 40'd4147200000;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_FRAME  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAGMENT_LENGTH = 2'd0,
    REG_HISTORY_LENGTH  = 2'd1,
    REG_CHANNEL_COUNT   = 2'd2,
    REG_SEARCH_LIMIT    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    opcode_t                     opcode;
    logic [CH_W-1:0]             channel;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [TIME_W-1:0]           time_stamp;
    logic                        frame_end;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic [CH_W-1:0]     out_channel;
    logic                last;
  } result_t;

  typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] peak_row_t;

endpackage

### hw/rtl/peak_level_history.sv
// Top level: per-channel peak meter with a time-stamped history ring and nearest-time query.
`timescale 1ns / 1ps
// Sample, frame start and clear items may follow back to back while no query is in progress.
// Query: one time slot a cycle through a shared subtract/compare pipe of three stages; the
//   input is not ready while the query runs through scan, pick and emit, and one result per
//   used channel follows the scan and the pick, each held until it is taken.
// Reset: synchronous, active high. A per-slot valid bit, dropped at once by reset and by
//   clear, makes unwritten slots read as time 0 and level 0; no clearing pass is needed.
module peak_level_history
  import plh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // item channel
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  // result channel
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  // register write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // ---------------- configuration registers ----------------
  logic [FRAG_W-1:0]  fragment_length;
  logic [HLEN_W-1:0]  history_length;
  logic [CHCNT_W-1:0] channel_count;
  logic [TIME_W-1:0]  search_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_length <= FRAG_RESET;
      history_length  <= HLEN_RESET;
      channel_count   <= CHCNT_RESET;
      search_limit    <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAGMENT_LENGTH: fragment_length <= cfg_data[FRAG_W-1:0];
        REG_HISTORY_LENGTH:  history_length  <= cfg_data[HLEN_W-1:0];
        REG_CHANNEL_COUNT:   channel_count   <= cfg_data[CHCNT_W-1:0];
        REG_SEARCH_LIMIT:    search_limit    <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: saturate to the built depth / channel count; a fragment length of 0 acts as 1
  logic [HLEN_W-1:0]  hist_len;
  logic [CHCNT_W-1:0] chans;
  logic [FRAG_W-1:0]  frag_len;

  assign hist_len = (history_length > HLEN_W'(HISTORY_DEPTH)) ? HLEN_W'(HISTORY_DEPTH)
                                                             : history_length;
  assign chans    = (channel_count > CHCNT_W'(MAX_CHANNELS)) ? CHCNT_W'(MAX_CHANNELS)
                                                            : channel_count;
  assign frag_len = (fragment_length == '0) ? FRAG_W'(1) : fragment_length;

  // ---------------- sequencer ----------------
  state_t state, state_next;

  logic                 accept;
  logic                 scan_issue;
  logic                 scan_done;
  logic                 emit_load;
  logic                 emit_last;

  logic [HLEN_W-1:0]    scan_idx;
  logic                 s1_ok, s2_ok;
  logic [CH_W-1:0]      emit_ch;

  assign accept    = item_valid && item_ready;
  assign scan_done = (scan_idx == hist_len) && !s1_ok && !s2_ok;
  assign emit_last = ({1'b0, emit_ch} == (chans - CHCNT_W'(1)));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && item.opcode == OP_QUERY && hist_len != '0 && chans != '0) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_load && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    scan_issue = 1'b0;
    emit_load  = 1'b0;
    unique case (state)
      ST_IDLE: item_ready = 1'b1;
      ST_SCAN: scan_issue = (scan_idx != hist_len);
      ST_PICK: ;
      ST_EMIT: emit_load = !result_valid || result_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- fragment accumulation ----------------
  peak_row_t           running_peak;
  logic [FRAG_W-1:0]   sample_position;
  logic [TIME_W-1:0]   frame_time;
  logic [SLOT_W-1:0]   write_slot;

  logic [SAMPLE_W-1:0] mag;
  logic                ch_used;
  logic                ch_last;
  peak_row_t           peak_upd;
  peak_row_t           commit_row;
  logic [FRAG_W:0]     pos_inc;
  logic                do_sample;
  logic                commit;
  logic                hist_on;
  logic [HLEN_W-1:0]   slot_base;
  logic [HLEN_W-1:0]   slot_inc;

  // magnitude in Q15; -32768 maps to 32768, which still fits 16 bits
  assign mag     = item.sample[SAMPLE_W-1] ? (~item.sample + SAMPLE_W'(1)) : item.sample;
  assign ch_used = ({1'b0, item.channel} < chans);
  assign ch_last = ({1'b0, item.channel} == (chans - CHCNT_W'(1)));
  assign pos_inc = {1'b0, sample_position} + (FRAG_W+1)'(1);

  assign do_sample = accept && item.opcode == OP_SAMPLE && ch_used;
  // a position closes on the highest used channel; frame_end only counts there
  assign commit    = do_sample && ch_last &&
                     ((pos_inc >= {1'b0, frag_len}) || item.frame_end);
  assign hist_on   = (hist_len != '0);

  always_comb begin
    peak_upd = running_peak;
    if (mag > running_peak[item.channel]) begin
      peak_upd[item.channel] = mag;
    end
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      commit_row[c] = (c < int'(chans)) ? peak_upd[c] : '0;
    end
  end

  // a write slot left beyond a shrunk ring restarts at slot 0
  assign slot_base = ({1'b0, write_slot} >= hist_len) ? '0 : {1'b0, write_slot};
  assign slot_inc  = slot_base + HLEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_peak    <= '0;
      sample_position <= '0;
      frame_time      <= '0;
      write_slot      <= '0;
    end else if (accept) begin
      unique case (item.opcode)
        OP_SAMPLE: begin
          if (commit) begin
            running_peak    <= '0;
            sample_position <= '0;
            frame_time      <= frame_time + TIME_W'(pos_inc);
            if (hist_on) begin
              write_slot <= (slot_inc >= hist_len) ? '0 : slot_inc[SLOT_W-1:0];
            end
          end else if (do_sample) begin
            running_peak <= peak_upd;
            if (ch_last) begin
              sample_position <= pos_inc[FRAG_W-1:0];
            end
          end
        end
        OP_FRAME: begin
          // an unfinished fragment is dropped
          running_peak    <= '0;
          sample_position <= '0;
          frame_time      <= item.time_stamp;
        end
        OP_CLEAR: write_slot <= '0;
        OP_QUERY: ;
        default: ;
      endcase
    end
  end

  // ---------------- history storage ----------------
  logic [HISTORY_DEPTH-1:0] slot_valid;
  logic                     hist_write;
  logic [SLOT_W-1:0]        wr_addr;

  assign hist_write = commit && hist_on;
  assign wr_addr    = slot_base[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (accept && item.opcode == OP_CLEAR) begin
      slot_valid <= '0;
    end else if (hist_write) begin
      slot_valid[wr_addr] <= 1'b1;
    end
  end

  logic [TIME_W-1:0] time_mem [HISTORY_DEPTH];
  logic [TIME_W-1:0] tm_rdata;
  peak_row_t         peak_mem [HISTORY_DEPTH];
  peak_row_t         pk_rdata;
  logic              pk_vld;

  always_ff @(posedge clk) begin
    if (hist_write) begin
      time_mem[wr_addr] <= frame_time;
    end
    if (scan_issue) begin
      tm_rdata <= time_mem[scan_idx[SLOT_W-1:0]];
    end
  end

  logic [SLOT_W-1:0] pick;

  always_ff @(posedge clk) begin
    if (hist_write) begin
      peak_mem[wr_addr] <= commit_row;
    end
    if (state == ST_PICK) begin
      pk_rdata <= peak_mem[pick];
    end
  end

  // ---------------- nearest-time scan ----------------
  // stage 1: slot time read; stage 2: absolute distance; stage 3: compare with best
  logic [TIME_W-1:0] query_ts;
  logic [TIME_W-1:0] best;
  logic [SLOT_W-1:0] s1_idx, s2_idx;
  logic              s1_vld;
  logic [TIME_W-1:0] s1_time;
  logic [TIME_W:0]   diff_a, diff_b;
  logic [TIME_W-1:0] gap, s2_dist;

  assign s1_time = s1_vld ? tm_rdata : '0;
  assign diff_a  = {1'b0, s1_time} - {1'b0, query_ts};
  assign diff_b  = {1'b0, query_ts} - {1'b0, s1_time};
  assign gap     = diff_a[TIME_W] ? diff_b[TIME_W-1:0] : diff_a[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      s1_ok    <= 1'b0;
      s2_ok    <= 1'b0;
    end else begin
      if (state == ST_IDLE) begin
        scan_idx <= '0;
      end else if (scan_issue) begin
        scan_idx <= scan_idx + HLEN_W'(1);
      end
      s1_ok <= scan_issue;
      s2_ok <= s1_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      query_ts <= item.time_stamp;
      best     <= search_limit;
      pick     <= '0;
    end else if (s2_ok && s2_dist < best) begin
      best <= s2_dist;
      pick <= s2_idx;
    end
    s1_idx  <= scan_idx[SLOT_W-1:0];
    s1_vld  <= slot_valid[scan_idx[SLOT_W-1:0]];
    s2_idx  <= s1_idx;
    s2_dist <= gap;
    if (state == ST_PICK) begin
      pk_vld <= slot_valid[pick];
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      emit_ch      <= '0;
    end else begin
      if (emit_load) begin
        result_valid <= 1'b1;
        emit_ch      <= emit_last ? '0 : emit_ch + CH_W'(1);
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      result.level       <= pk_vld ? pk_rdata[emit_ch] : '0;
      result.out_channel <= emit_ch;
      result.last        <= emit_last;
    end
  end

endmodule
